>>> src/supl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package supl_pkg;

  localparam int DepthDefault = 32;

  localparam int IdW       = 32;
  localparam int ScoreW    = 8;
  localparam int KeyW      = ScoreW + 1;
  localparam int RankW     = 5;
  localparam int CmdW      = 2;
  localparam int StatusW   = 2;
  localparam int CountOutW = 6;

  localparam logic [CmdW-1:0] CMD_INSERT = 2'd0;
  localparam logic [CmdW-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CmdW-1:0] CMD_READ   = 2'd2;

  localparam logic [StatusW-1:0] ST_OK      = 2'd0;
  localparam logic [StatusW-1:0] ST_DUP     = 2'd1;
  localparam logic [StatusW-1:0] ST_MISSING = 2'd2;
  localparam logic [StatusW-1:0] ST_FULL    = 2'd3;

  typedef logic [KeyW-1:0] key_t;

  typedef struct packed {
    logic              valid;
    logic [IdW-1:0]    id;
    logic [ScoreW-1:0] score;
    logic              group;
  } entry_t;

  typedef struct packed {
    logic eval;
    logic insert_go;
    logic remove_go;
  } ctl_t;

endpackage

`default_nettype wire

>>> src/sorted_unique_priority_list_core.sv
// Sorted list of up to TABLE_DEPTH unique entries (id, score, group), kept in
// descending order of score, then group, in a chain of cells. At the input
// beat every cell compares its entry with the command in parallel and
// registers its flags; in S_DONE, once the output is free, the chain shifts one
// place to open or close a gap and the result is loaded into the output
// register. An insert lands after all entries with an equal or higher key.
// The next beat is taken once the previous result is loaded; a result waiting
// on the output stalls only the shift and load of the next command. Ranks
// beyond 31 are not readable; entry_count carries the low 6 bits of count.
`timescale 1ns / 1ps
`default_nettype none

module sorted_unique_priority_list_core #(
  parameter int TABLE_DEPTH = supl_pkg::DepthDefault
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire [supl_pkg::CmdW-1:0]      command,
  input  wire [supl_pkg::IdW-1:0]       entry_id,
  input  wire [supl_pkg::ScoreW-1:0]    score,
  input  wire                           group,
  input  wire [supl_pkg::RankW-1:0]     rank,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [supl_pkg::StatusW-1:0]  status,
  output logic [supl_pkg::IdW-1:0]      out_id,
  output logic [supl_pkg::ScoreW-1:0]   out_score,
  output logic                          out_group,
  output logic [supl_pkg::CountOutW-1:0] entry_count
);
  import supl_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DONE = 2'b10
  } state_t;

  state_t state;

  logic [CmdW-1:0]   req_cmd;
  logic [IdW-1:0]    req_id;
  logic [ScoreW-1:0] req_score;
  logic              req_group;
  logic [RankW-1:0]  req_rank;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  ctl_t   ctl;
  entry_t new_ent;
  entry_t cells [TABLE_DEPTH];
  logic   [TABLE_DEPTH-1:0] hit_vec;
  logic   [TABLE_DEPTH-1:0] ins_vec;
  logic   [TABLE_DEPTH-1:0] valid_vec;
  logic   [TABLE_DEPTH-1:0] shift_vec;

  logic              in_beat;
  logic              finish;
  logic              found;
  logic              full;
  logic [IW-1:0]     hit_pos;
  entry_t            rd_ent;
  logic              rd_ok;

  logic [StatusW-1:0] st_next;
  entry_t             data_next;

  assign in_ready = (state == S_IDLE);
  assign in_beat  = in_valid && in_ready;
  assign finish   = (state == S_DONE) && (!out_valid || out_ready);
  assign new_ent  = '{valid: 1'b1, id: req_id, score: req_score, group: req_group};

  // chain of cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    entry_t left_ent;
    entry_t right_ent;
    logic   left_ins;
    if (i == 0) begin : g_first
      assign left_ent = '0;
      assign left_ins = 1'b0;
    end else begin : g_mid
      assign left_ent = cells[i-1];
      assign left_ins = ins_vec[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign right_ent = '0;
    end else begin : g_inner
      assign right_ent = cells[i+1];
    end
    assign valid_vec[i] = cells[i].valid;
    assign shift_vec[i] = found && (int'(hit_pos) <= i);

    supl_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .cmp_id    (entry_id),
      .cmp_key   ({score, group}),
      .new_ent   (new_ent),
      .left_ent  (left_ent),
      .left_ins  (left_ins),
      .right_ent (right_ent),
      .shift_up  (shift_vec[i]),
      .ent       (cells[i]),
      .hit       (hit_vec[i]),
      .ins       (ins_vec[i])
    );
  end

  always_comb begin
    found   = |hit_vec;
    full    = (int'(count) >= TABLE_DEPTH);
    hit_pos = '0;
    rd_ent  = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (hit_vec[i]) hit_pos = hit_pos | IW'(i);
      if (int'(req_rank) == i) rd_ent = rd_ent | cells[i];
    end
    rd_ok = (int'(req_rank) < int'(count)) && rd_ent.valid;
  end

  always_comb begin
    ctl.eval      = in_beat;
    ctl.insert_go = 1'b0;
    ctl.remove_go = 1'b0;
    st_next       = ST_OK;
    data_next     = '0;
    count_next    = count;
    case (req_cmd)
      CMD_INSERT: begin
        if (found) begin
          st_next = ST_DUP;
        end else if (full) begin
          st_next = ST_FULL;
        end else begin
          ctl.insert_go = finish;
          count_next    = count + CW'(1);
        end
      end
      CMD_REMOVE: begin
        if (!found) begin
          st_next = ST_MISSING;
        end else begin
          ctl.remove_go = finish;
          count_next    = count - CW'(1);
        end
      end
      CMD_READ: begin
        if (rd_ok) begin
          data_next = rd_ent;
        end else begin
          st_next = ST_MISSING;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_beat) state <= S_DONE;
        end
        S_DONE: begin
          if (finish) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (finish) begin
        out_valid <= 1'b1;
        count     <= count_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      req_cmd   <= command;
      req_id    <= entry_id;
      req_score <= score;
      req_group <= group;
      req_rank  <= rank;
    end
    if (finish) begin
      status      <= st_next;
      out_id      <= data_next.id;
      out_score   <= data_next.score;
      out_group   <= data_next.group;
      entry_count <= CountOutW'(count_next);
    end
  end

  a_packed_count: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(count))
    else $error("valid cells disagree with entry count");

  a_insert_not_full: assert property (@(posedge clk) disable iff (rst)
    ctl.insert_go |-> (!full && !found))
    else $error("insert applied to full table or duplicate id");

  a_remove_drop: assert property (@(posedge clk) disable iff (rst)
    ctl.remove_go |=> (count == $past(count) - CW'(1)))
    else $error("remove did not shrink the table");

  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    $onehot0(hit_vec))
    else $error("id held by more than one cell");

endmodule

`default_nettype wire

>>> src/supl_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module supl_cell (
  input  wire                     clk,
  input  wire                     rst,
  input  supl_pkg::ctl_t          ctl,
  input  wire [supl_pkg::IdW-1:0] cmp_id,
  input  supl_pkg::key_t          cmp_key,
  input  supl_pkg::entry_t        new_ent,
  input  supl_pkg::entry_t        left_ent,
  input  wire                     left_ins,
  input  supl_pkg::entry_t        right_ent,
  input  wire                     shift_up,
  output supl_pkg::entry_t        ent,
  output logic                    hit,
  output logic                    ins
);
  import supl_pkg::*;

  key_t own_key;
  assign own_key = {ent.score, ent.group};

  // compare flags, taken at the input beat
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
      ins <= 1'b0;
    end else if (ctl.eval) begin
      hit <= ent.valid && (ent.id == cmp_id);
      ins <= !ent.valid || (own_key < cmp_key);
    end
  end

  // shift right on insert, shift left on remove
  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else if (ctl.insert_go && ins) begin
      ent <= left_ins ? left_ent : new_ent;
    end else if (ctl.remove_go && shift_up) begin
      ent <= right_ent;
    end
  end

endmodule

`default_nettype wire

>>> bench/tb_sorted_unique_priority_list_core.sv
`timescale 1ns / 1ps

module tb_sorted_unique_priority_list_core;
  import supl_pkg::*;

  localparam int Depth = DepthDefault;
  localparam int RandomItems = 1350;
  localparam int HoldCycles = 200;
  localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [StatusW-1:0]   status;
    logic [IdW-1:0]       id;
    logic [ScoreW-1:0]    score;
    logic                 grp;
    logic [CountOutW-1:0] count;
  } list_result_t;

  typedef enum logic [1:0] {PH_FILL, PH_MIX, PH_DRAIN} phase_t;

  class list_scoreboard;
    entry_t rows[$];
    list_result_t expected_q[$];
    int errors;
    int results_seen;

    function int find_id(logic [IdW-1:0] id);
      foreach (rows[i]) begin
        if (rows[i].id == id) return i;
      end
      return -1;
    endfunction

    function logic [IdW-1:0] random_present_id();
      return rows[$urandom_range(0, rows.size() - 1)].id;
    endfunction

    // predict the result of one accepted input beat
    function void note_beat(logic [CmdW-1:0] cmd, logic [IdW-1:0] id,
                            logic [ScoreW-1:0] sc, logic grp, logic [RankW-1:0] rk);
      list_result_t r;
      entry_t e;
      int pos;
      r = '0;
      r.status = ST_OK;
      case (cmd)
        CMD_INSERT: begin
          if (find_id(id) >= 0) begin
            r.status = ST_DUP;
          end else if (rows.size() >= Depth) begin
            r.status = ST_FULL;
          end else begin
            pos = rows.size();
            for (int i = 0; i < rows.size(); i++) begin
              if (key_t'({rows[i].score, rows[i].group}) < key_t'({sc, grp})) begin
                pos = i;
                break;
              end
            end
            e.valid = 1'b1;
            e.id = id;
            e.score = sc;
            e.group = grp;
            rows.insert(pos, e);
          end
        end
        CMD_REMOVE: begin
          pos = find_id(id);
          if (pos < 0) r.status = ST_MISSING;
          else rows.delete(pos);
        end
        CMD_READ: begin
          if (rk < rows.size()) begin
            r.id = rows[rk].id;
            r.score = rows[rk].score;
            r.grp = rows[rk].group;
          end else begin
            r.status = ST_MISSING;
          end
        end
        default: ;
      endcase
      r.count = CountOutW'(rows.size());
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string field, logic [IdW-1:0] got, logic [IdW-1:0] want);
      errors++;
      $display("result %0d: %s got %0h, expected %0h", results_seen, field, got, want);
    endtask

    task check_beat(list_result_t got);
      list_result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result, status", IdW'(got.status), '0);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status)
        report_mismatch("status", IdW'(got.status), IdW'(want.status));
      if (got.id !== want.id) report_mismatch("out_id", got.id, want.id);
      if (got.score !== want.score)
        report_mismatch("out_score", IdW'(got.score), IdW'(want.score));
      if (got.grp !== want.grp)
        report_mismatch("out_group", IdW'(got.grp), IdW'(want.grp));
      if (got.count !== want.count)
        report_mismatch("entry_count", IdW'(got.count), IdW'(want.count));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CmdW-1:0] command = CMD_READ;
  logic [IdW-1:0] entry_id = '0;
  logic [ScoreW-1:0] score = '0;
  logic group = 1'b0;
  logic [RankW-1:0] rank = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [StatusW-1:0] status;
  logic [IdW-1:0] out_id;
  logic [ScoreW-1:0] out_score;
  logic out_group;
  logic [CountOutW-1:0] entry_count;

  logic hold_req = 1'b0;
  int burst_left = 0;
  list_scoreboard sb = new();

  always #5 clk = ~clk;

  sorted_unique_priority_list_core #(.TABLE_DEPTH(Depth)) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .entry_id(entry_id),
    .score(score),
    .group(group),
    .rank(rank),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .out_id(out_id),
    .out_score(out_score),
    .out_group(out_group),
    .entry_count(entry_count)
  );

  task automatic send_command(input logic [CmdW-1:0] cmd, input logic [IdW-1:0] id,
                              input logic [ScoreW-1:0] sc, input logic grp,
                              input logic [RankW-1:0] rk);
    int gap;
    in_valid <= 1'b1;
    command <= cmd;
    entry_id <= id;
    score <= sc;
    group <= grp;
    rank <= rk;
    do @(posedge clk); while (!in_ready);
    sb.note_beat(cmd, id, sc, grp, rk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random(input phase_t ph);
    int roll;
    int ins_lim;
    int rem_lim;
    logic [CmdW-1:0] cmd;
    logic [IdW-1:0] id;
    logic [ScoreW-1:0] sc;
    logic [RankW-1:0] rk;
    int hi;
    case (ph)
      PH_FILL: begin
        ins_lim = 80;
        rem_lim = 88;
      end
      PH_DRAIN: begin
        ins_lim = 15;
        rem_lim = 80;
      end
      default: begin
        ins_lim = 40;
        rem_lim = 70;
      end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < ins_lim) cmd = CMD_INSERT;
    else if (roll < rem_lim) cmd = CMD_REMOVE;
    else if (roll < 97) cmd = CMD_READ;
    else cmd = CMD_UNUSED;

    id = $urandom();
    if (cmd == CMD_INSERT) begin
      if (sb.rows.size() > 0 && $urandom_range(0, 9) == 0) begin
        id = sb.random_present_id();
      end else begin
        case ($urandom_range(0, 19))
          0: id = '0;
          1: id = '1;
          default: ;
        endcase
      end
    end else if (cmd == CMD_REMOVE && sb.rows.size() > 0 && $urandom_range(0, 3) != 0) begin
      id = sb.random_present_id();
    end

    case ($urandom_range(0, 3))
      0: sc = ScoreW'($urandom_range(0, 255));
      1: sc = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: sc = ScoreW'($urandom_range(100, 103));
    endcase

    hi = (sb.rows.size() + 1 > 31) ? 31 : sb.rows.size() + 1;
    rk = ($urandom_range(0, 3) == 0) ? RankW'($urandom_range(0, 31))
                                     : RankW'($urandom_range(0, hi));

    send_command(cmd, id, sc, 1'($urandom_range(0, 1)), rk);
  endtask

  initial begin
    list_result_t got;
    int hold_left;
    int rx_cycle;
    int rx_mode;
    hold_left = 0;
    rx_cycle = 0;
    rx_mode = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got.status = status;
        got.id = out_id;
        got.score = out_score;
        got.grp = out_group;
        got.count = entry_count;
        sb.check_beat(got);
      end
      rx_cycle++;
      if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req <= 1'b0;
        hold_left = HoldCycles;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (rx_cycle % 3 == 0);
        endcase
      end
    end
  end

  initial begin
    #3ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int sent;
    int k;
    int plen;
    phase_t ph;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table, unused code, extreme ids and keys, ties, duplicate
    send_command(CMD_READ, '0, '0, 1'b0, 5'd0);
    send_command(CMD_READ, '1, '1, 1'b1, 5'd31);
    send_command(CMD_REMOVE, '0, '0, 1'b0, 5'd0);
    send_command(CMD_UNUSED, 32'hA5A5_5A5A, 8'hC3, 1'b1, 5'd17);
    send_command(CMD_INSERT, '0, 8'h00, 1'b0, 5'd0);
    send_command(CMD_INSERT, '1, 8'hFF, 1'b1, 5'd31);
    send_command(CMD_INSERT, 32'd5, 8'hFF, 1'b0, 5'd0);
    send_command(CMD_INSERT, 32'd6, 8'hFF, 1'b1, 5'd0);
    send_command(CMD_INSERT, 32'd7, 8'h00, 1'b0, 5'd0);
    send_command(CMD_INSERT, '0, 8'd100, 1'b1, 5'd0);
    for (int r = 0; r < 6; r++) send_command(CMD_READ, '0, '0, 1'b0, RankW'(r));
    send_command(CMD_READ, '0, '0, 1'b0, 5'd31);
    send_command(CMD_REMOVE, 32'd6, '0, 1'b0, 5'd0);
    send_command(CMD_REMOVE, '1, '0, 1'b0, 5'd0);
    send_command(CMD_REMOVE, 32'd7, '0, 1'b0, 5'd0);
    send_command(CMD_REMOVE, 32'd7, '0, 1'b0, 5'd0);
    send_command(CMD_READ, '0, '0, 1'b0, 5'd0);
    send_command(CMD_READ, '0, '0, 1'b0, 5'd1);
    send_command(CMD_UNUSED, '1, '1, 1'b1, 5'd31);

    sent = 0;
    k = 0;
    while (sent < RandomItems) begin
      case (k % 4)
        0: ph = PH_FILL;
        2: ph = PH_DRAIN;
        default: ph = PH_MIX;
      endcase
      plen = $urandom_range(50, 110);
      for (int j = 0; j < plen && sent < RandomItems; j++) begin
        // long receiver hold-off while the sender keeps offering beats
        if (sent == 300 || sent == 900) hold_req <= 1'b1;
        send_random(ph);
        sent++;
      end
      k++;
    end
    if (in_valid) in_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/supl_pkg.sv
src/supl_cell.sv
src/sorted_unique_priority_list_core.sv
bench/tb_sorted_unique_priority_list_core.sv
